// ----- src/mono_framebuffer_text_plotter_assert.svh -----
// Assertion macros for the framebuffer plotter checker.
`ifndef MONO_FRAMEBUFFER_TEXT_PLOTTER_ASSERT_SVH
`define MONO_FRAMEBUFFER_TEXT_PLOTTER_ASSERT_SVH

// Implication checked on every rising clock edge, off while reset is active.
`define MFTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define MFTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/mfbtp_pkg.sv -----
`default_nettype none
package mfbtp_pkg;

    typedef enum logic [2:0] {
        CMD_PLOT    = 3'd0,
        CMD_CHAR    = 3'd1,
        CMD_SET_COL = 3'd2,
        CMD_SET_ROW = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    localparam logic [1:0] MODE_CLR  = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_INV  = 2'd2;
    localparam logic [1:0] MODE_KEEP = 2'd3;

    localparam logic [7:0] CODE_NEWLINE  = 8'h0A;
    localparam logic [7:0] GLYPH_FIRST   = 8'h20;
    localparam logic [7:0] GLYPH_LAST    = 8'h7F;
    localparam logic [7:0] GLYPH_FALLBACK = 8'h3F;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = 10;

    // 6-column glyph ROM for codes 0x20..0x7F, packed as col0 in the high byte.
    localparam logic [47:0] GLYPH_ROM [96] = '{
        48'h000000000000, 48'h0000002f0000, 48'h000007000700, 48'h00147f147f14,
        48'h00242a7f2a12, 48'h002313086462, 48'h003649552250, 48'h000005030000,
        48'h00001c224100, 48'h000041221c00, 48'h0014083E0814, 48'h0008083E0808,
        48'h000000A06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
        48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
        48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
        48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
        48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
        48'h00324959513E, 48'h007C1211127C, 48'h007F49494936, 48'h003E41414122,
        48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
        48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01,
        48'h007F08142241, 48'h007F40404040, 48'h007F020C027F, 48'h007F0408107F,
        48'h003E4141413E, 48'h007F09090906, 48'h003E4151215E, 48'h007F09192946,
        48'h004649494931, 48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F,
        48'h003F4038403F, 48'h006314081463, 48'h000708700807, 48'h006151494543,
        48'h00007F414100, 48'h00552A552A55, 48'h000041417F00, 48'h000402010204,
        48'h004040404040, 48'h000001020400, 48'h002054545478, 48'h007F48444438,
        48'h003844444420, 48'h00384444487F, 48'h003854545418, 48'h00087E090102,
        48'h0018A4A4A47C, 48'h007F08040478, 48'h0000447D4000, 48'h004080847D00,
        48'h007F10284400, 48'h0000417F4000, 48'h007C04180478, 48'h007C08040478,
        48'h003844444438, 48'h00FC24242418, 48'h0018242418FC,
        48'h007C08040408, 48'h004854545420, 48'h00043F444020, 48'h003C4040207C,
        48'h001C2040201C, 48'h003C4030403C, 48'h004428102844, 48'h001CA0A0A07C,
        48'h004464544C44, 48'h000008770000, 48'h0000007F0000, 48'h000077080000,
        48'h001008100800, 48'h141414141414
    };

endpackage
`default_nettype wire

// ----- src/mono_framebuffer_text_plotter.sv -----
// Channel | Dir | tdata fields (low bit up)                        | tuser
// s_axis  | in  | command[2:0] pos_x[18:3] pos_y[34:19] color[36:35] | -
//         |     | char_code[44:37] read_index[54:45], 56 bits       |
// m_axis  | out | read_data[7:0] cursor_col_px[15:8] row_px[23:16]  | -
//
// One item at a time. Plot, read: set up, store read, then write or capture,
// then output. Set cursor, newline, unused codes: set up, then output.
// Put-char: 16 steps, upper and lower store byte of 8 columns; a byte on screen
// is set up, read and written, any other step only advances. Rows are page
// aligned, so at most 8 bytes change. Clear and reset: a pass over STORE_DEPTH
// bytes, one byte a cycle; after reset no transfer is accepted until it ends.
// s_axis_tready is low while an item is in work or a result waits in m_axis.
`default_nettype none
module mono_framebuffer_text_plotter
    import mfbtp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // command, pos_x, pos_y, color_mode,
                                            // char_code, read_index, pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // read_data, cursor_col_px, cursor_row_px
);
    localparam int PAGES = SCREEN_HEIGHT / 8;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_PREP, ST_RD, ST_WR, ST_OUT
    } state_t;

    state_t state_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [2:0]  cmd_reg;
    logic signed [15:0] px_reg, py_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  code_reg;
    logic [ADDR_W-1:0] ridx_reg;
    logic [7:0]  cx_reg, cy_reg;
    logic [7:0]  rdata_reg;
    logic [3:0]  step_reg;       // char: col in [3:1], page in [0]
    logic [47:0] glyph_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]  setm_reg, clrm_reg, invm_reg;
    logic        touch_reg;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] mem_q;

    // Memory: one read and one write port, registered read.
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        mem_q <= mem[addr_reg];
    end

    // Char step: column col = step[3:1], page offset step[0].
    logic [2:0]  col;
    logic [8:0]  gx, gy;
    logic [7:0]  line;
    logic [15:0] line16, shl;
    logic [7:0]  rowok;
    always_comb
    begin
        col   = step_reg[3:1];
        gx    = {1'b0, cx_reg} + {6'd0, col};
        gy    = {1'b0, cy_reg[7:3], 3'd0} + (step_reg[0] ? 9'd8 : 9'd0);
        line  = (col < 3'd6) ? glyph_reg[8'(47 - 8*col) -: 8] : 8'd0;
        line16 = {8'd0, line} << cy_reg[2:0];
        shl   = {8'hFF, 8'hFF} << cy_reg[2:0];
        for (int i = 0; i < 8; i++)
        begin
            rowok[i] = (gy + 9'(i)) < 9'(SCREEN_HEIGHT);
        end
    end

    logic [7:0] hm, hl;   // cell mask bytes
    always_comb
    begin
        hm = step_reg[0] ? ~shl[7:0] : shl[7:0];
        hl = step_reg[0] ? line16[15:8] : line16[7:0];
        hm = hm & rowok;
    end

    // Current step lands on screen with at least one row to write.
    logic cell_vis;
    assign cell_vis = (gx < 9'(SCREEN_WIDTH)) && (hm != 8'd0);

    logic [7:0] code_fix;
    always_comb
    begin
        code_fix = (code_reg < GLYPH_FIRST) ? GLYPH_FALLBACK :
                   (code_reg > GLYPH_LAST)  ? GLYPH_FALLBACK : code_reg;
        we = 1'b0;
        wa = addr_reg;
        wd = (mem_q & ~clrm_reg & ~setm_reg) ^ invm_reg | setm_reg;
        if (state_reg == ST_CLEAR)
        begin
            we = 1'b1;
            wa = clr_reg;
            wd = 8'd0;
        end
        else if (state_reg == ST_WR && touch_reg)
        begin
            we = 1'b1;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {cy_reg, cx_reg, rdata_reg};

    logic last_step;
    assign last_step = (step_reg == 4'd15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cmd_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            step_reg  <= '0;
            touch_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                    begin
                        state_reg <= cmd_reg == CMD_CLEAR ? ST_OUT : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg   <= s_axis_tdata[2:0];
                        px_reg    <= s_axis_tdata[18:3];
                        py_reg    <= s_axis_tdata[34:19];
                        mode_reg  <= s_axis_tdata[36:35];
                        code_reg  <= s_axis_tdata[44:37];
                        ridx_reg  <= s_axis_tdata[54:45];
                        rdata_reg <= '0;
                        step_reg  <= '0;
                        touch_reg <= 1'b0;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    case (cmd_reg)
                        CMD_PLOT:
                        begin
                            addr_reg <= ADDR_W'(32'(px_reg) * PAGES + 32'(py_reg[15:3]));
                            touch_reg <= px_reg >= 0 && px_reg < 16'(SCREEN_WIDTH) &&
                                         py_reg >= 0 && py_reg < 16'(SCREEN_HEIGHT) &&
                                         mode_reg != MODE_KEEP;
                            setm_reg <= mode_reg == MODE_SET ? 8'(1 << py_reg[2:0]) : 8'd0;
                            clrm_reg <= mode_reg == MODE_CLR ? 8'(1 << py_reg[2:0]) : 8'd0;
                            invm_reg <= mode_reg == MODE_INV ? 8'(1 << py_reg[2:0]) : 8'd0;
                            state_reg <= ST_RD;
                        end
                        CMD_CHAR:
                        begin
                            if (code_reg == CODE_NEWLINE)
                            begin
                                cx_reg    <= '0;
                                cy_reg    <= cy_reg + 8'd8;
                                state_reg <= ST_OUT;
                            end
                            else
                            begin
                                glyph_reg <= GLYPH_ROM[7'(code_fix - GLYPH_FIRST)];
                                state_reg <= ST_WR;  // first pass through WR sets up or skips a step
                            end
                        end
                        CMD_SET_COL:
                        begin
                            cx_reg    <= {px_reg[4:0], 3'd0};
                            state_reg <= ST_OUT;
                        end
                        CMD_SET_ROW:
                        begin
                            cy_reg    <= {py_reg[4:0], 3'd0};
                            state_reg <= ST_OUT;
                        end
                        CMD_CLEAR:
                        begin
                            clr_reg   <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            addr_reg  <= ridx_reg;
                            state_reg <= ST_RD;
                        end
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_RD:
                begin
                    state_reg <= ST_WR;
                end
                ST_WR:
                begin
                    if (cmd_reg == CMD_READ)
                    begin
                        rdata_reg <= mem_q;
                        state_reg <= ST_OUT;
                    end
                    else if (cmd_reg == CMD_PLOT)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (touch_reg)
                    begin
                        // char: byte written this cycle, move on or finish
                        touch_reg <= 1'b0;
                        if (last_step)
                        begin
                            cx_reg    <= cx_reg + 8'd8;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                    else if (cell_vis)
                    begin
                        // char: set up the read-modify-write of this step's byte
                        addr_reg  <= ADDR_W'(32'(gx) * PAGES + 32'(gy[8:3]));
                        setm_reg  <= hl & hm;
                        clrm_reg  <= ~hl & hm;
                        invm_reg  <= '0;
                        touch_reg <= 1'b1;
                        state_reg <= ST_RD;
                    end
                    else if (last_step)
                    begin
                        cx_reg    <= cx_reg + 8'd8;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/mfbtp_checker.sv -----
`default_nettype none
`include "mono_framebuffer_text_plotter_assert.svh"
module mfbtp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [55:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    `MFTP_ASSERT_IMP(no_take_while_out, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `MFTP_ASSERT_NEXT(out_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `MFTP_ASSERT_NEXT(take_starts_work, clk, rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready && !m_axis_tvalid)
    `MFTP_ASSERT_NEXT(in_holds, clk, rst_n, s_axis_tvalid && !s_axis_tready,
        s_axis_tvalid && $stable(s_axis_tdata))
endmodule

bind mono_framebuffer_text_plotter mfbtp_checker u_chk (.*);
`default_nettype wire

// ----- test/mono_framebuffer_text_plotter_tb.sv -----
`default_nettype none
module mono_framebuffer_text_plotter_tb;
    import mfbtp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 128;
    localparam int SH = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] row_px;
        logic [7:0] col_px;
        logic [7:0] read_data;
    } frame_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // command, pos_x, pos_y, color_mode, char_code, read_index
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // read_data, cursor_col_px, cursor_row_px

    mono_framebuffer_text_plotter #(.SCREEN_WIDTH(SW), .SCREEN_HEIGHT(SH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow copy of the block's state.
    logic [7:0] shadow_fb [STORE_DEPTH];
    logic [7:0] shadow_cx;
    logic [7:0] shadow_cy;

    frame_result_t pending_results[$];
    int  error_count;
    int  cycle_count;
    int  sink_wait;

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %02h want %02h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // One pixel update, clipped to the screen.
    function automatic void shade_pixel(input int x, input int y, input logic [1:0] mode);
        int  addr;
        logic [7:0] mask;
        if (x < 0 || x >= SW || y < 0 || y >= SH)
            return;
        addr = (x * (SH / 8) + y / 8) % STORE_DEPTH;
        mask = 8'h01 << (y % 8);
        case (mode)
            MODE_CLR: shadow_fb[addr] &= ~mask;
            MODE_SET: shadow_fb[addr] |= mask;
            MODE_INV: shadow_fb[addr] ^= mask;
            default: ;
        endcase
    endfunction

    // Cell is 6 glyph columns then 2 blank ones; glyph bits overwrite pixels.
    function automatic void render_cell(input logic [7:0] code);
        logic [7:0]  glyph_idx;
        logic [47:0] glyph;
        logic [7:0]  column;
        if (code < GLYPH_FIRST || code > GLYPH_LAST)
            code = GLYPH_FALLBACK;
        glyph_idx = code - GLYPH_FIRST;
        glyph = GLYPH_ROM[glyph_idx];
        for (int c = 0; c < 8; c++)
        begin
            column = (c < 6) ? glyph[47 - 8*c -: 8] : 8'h00;
            for (int r = 0; r < 8; r++)
                shade_pixel(int'(shadow_cx) + c, int'(shadow_cy) + r, {1'b0, column[r]});
        end
    endfunction

    function automatic frame_result_t plotter_outcome(input logic [2:0] cmd,
            input logic signed [15:0] px, input logic signed [15:0] py,
            input logic [1:0] mode, input logic [7:0] code, input logic [9:0] ridx);
        frame_result_t res;
        res.read_data = 8'h00;
        case (cmd)
            CMD_PLOT: shade_pixel(int'(px), int'(py), mode);
            CMD_CHAR:
            begin
                if (code == CODE_NEWLINE)
                begin
                    shadow_cx = 8'h00;
                    shadow_cy += 8'd8;
                end
                else
                begin
                    render_cell(code);
                    shadow_cx += 8'd8;
                end
            end
            CMD_SET_COL: shadow_cx = {px[4:0], 3'b000};
            CMD_SET_ROW: shadow_cy = {py[4:0], 3'b000};
            CMD_CLEAR:   foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
            CMD_READ:    res.read_data = shadow_fb[ridx];
            default: ;
        endcase
        res.col_px = shadow_cx;
        res.row_px = shadow_cy;
        return res;
    endfunction

    // Send one command transfer after a random gap; predict at acceptance.
    task automatic send_command(input logic [2:0] cmd, input logic signed [15:0] px,
            input logic signed [15:0] py, input logic [1:0] mode,
            input logic [7:0] code, input logic [9:0] ridx);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ridx, code, mode, py, px, cmd};
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(plotter_outcome(cmd, px, py, mode, code, ridx));
    endtask

    function automatic logic [9:0] rand_addr();
        return 10'($urandom_range(0, STORE_DEPTH - 1));
    endfunction

    // Coordinates mostly on screen, sometimes near or far off.
    function automatic logic signed [15:0] rand_coord(input int span);
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'(span + $urandom_range(0, 3));
            2: return -16'sd1 - 16'($urandom_range(0, 3));
            default: return 16'($urandom_range(0, span - 1));
        endcase
    endfunction

    // Result side: a drawn random stall per result, compare every transfer.
    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got, want;
        int w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b1;
            sink_wait     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", got.read_data, 8'h00);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.col_px !== want.col_px)
                        report_mismatch("cursor_col_px", got.col_px, want.col_px);
                    if (got.row_px !== want.row_px)
                        report_mismatch("cursor_row_px", got.row_px, want.row_px);
                end
                w = $urandom_range(0, 6);
                sink_wait     <= w;
                m_axis_tready <= (w == 0);
            end
            else if (m_axis_tvalid && !m_axis_tready)
            begin
                if (sink_wait <= 1)
                    m_axis_tready <= 1'b1;
                sink_wait <= sink_wait - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_edge_plots();
        send_command(CMD_PLOT, 16'sd0, 16'sd0, MODE_SET, 8'h00, 10'd0);
        send_command(CMD_PLOT, 16'(SW - 1), 16'(SH - 1), MODE_SET, 8'h00, 10'd0);
        send_command(CMD_PLOT, 16'(SW), 16'sd0, MODE_SET, 8'h00, 10'd0);
        send_command(CMD_PLOT, -16'sd1, 16'sd5, MODE_SET, 8'h00, 10'd0);
        send_command(CMD_PLOT, 16'sd3, 16'(SH), MODE_SET, 8'h00, 10'd0);
        send_command(CMD_PLOT, 16'sh7FFF, 16'sh8000, MODE_SET, 8'hFF, 10'h3FF);
        send_command(CMD_PLOT, 16'sd0, 16'sd0, MODE_INV, 8'h00, 10'd0);
        send_command(CMD_PLOT, 16'(SW - 1), 16'(SH - 1), MODE_CLR, 8'h00, 10'd0);
        send_command(CMD_PLOT, 16'sd5, 16'sd5, MODE_KEEP, 8'h00, 10'd0);
        send_command(CMD_READ, 16'sd0, 16'sd0, MODE_CLR, 8'h00, 10'd0);
        send_command(CMD_READ, 16'sd0, 16'sd0, MODE_CLR, 8'h00, 10'h3FF);
    endtask

    task automatic test_text_cells();
        send_command(CMD_CHAR, 16'sd0, 16'sd0, MODE_CLR, 8'h41, 10'd0);
        send_command(CMD_CHAR, 16'sd0, 16'sd0, MODE_CLR, 8'h7F, 10'd0); // horizontal lines
        send_command(CMD_CHAR, 16'sd0, 16'sd0, MODE_CLR, 8'h05, 10'd0); // control code: '?'
        send_command(CMD_CHAR, 16'sd0, 16'sd0, MODE_CLR, 8'hFF, 10'd0); // high code: '?'
        send_command(CMD_CHAR, 16'sd0, 16'sd0, MODE_CLR, CODE_NEWLINE, 10'd0);
        send_command(CMD_SET_COL, 16'sd15, 16'sd0, MODE_CLR, 8'h00, 10'd0); // right edge
        send_command(CMD_SET_ROW, 16'sd0, 16'sd7, MODE_CLR, 8'h00, 10'd0);
        send_command(CMD_CHAR, 16'sd0, 16'sd0, MODE_CLR, 8'h20, 10'd0);
        send_command(CMD_SET_COL, 16'sd31, 16'sd0, MODE_CLR, 8'h00, 10'd0); // wraps past 256
        send_command(CMD_SET_ROW, 16'sd0, -16'sd1, MODE_CLR, 8'h00, 10'd0);
        send_command(CMD_CHAR, 16'sd0, 16'sd0, MODE_CLR, 8'h4D, 10'd0);
        send_command(CMD_CHAR, 16'sd0, 16'sd0, MODE_CLR, CODE_NEWLINE, 10'd0);
        send_command(CMD_READ, 16'sd0, 16'sd0, MODE_CLR, 8'h00, 10'd1);
        send_command(3'd6, 16'sd0, 16'sd0, MODE_CLR, 8'h00, 10'd0);
        send_command(3'd7, 16'sd0, 16'sd0, MODE_CLR, 8'h00, 10'd0);
        send_command(CMD_CLEAR, 16'sd0, 16'sd0, MODE_CLR, 8'h00, 10'd0);
    endtask

    // Mostly text runs and plots with readbacks; occasional clears and noise.
    task automatic test_random_traffic(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_command(CMD_CHAR, 16'($urandom), 16'($urandom), 2'($urandom),
                             ($urandom_range(0, 9) == 0) ? CODE_NEWLINE : 8'($urandom),
                             10'($urandom));
            else if (pick < 55)
                send_command(CMD_PLOT, rand_coord(SW), rand_coord(SH), 2'($urandom),
                             8'($urandom), 10'($urandom));
            else if (pick < 80)
                send_command(CMD_READ, 16'($urandom), 16'($urandom), 2'($urandom),
                             8'($urandom), rand_addr());
            else if (pick < 87)
                send_command(CMD_SET_COL, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                             : 16'($urandom_range(0, 17)), 16'($urandom), 2'($urandom),
                             8'($urandom), 10'($urandom));
            else if (pick < 94)
                send_command(CMD_SET_ROW, 16'($urandom), ($urandom_range(0, 3) == 0)
                             ? 16'($urandom) : 16'($urandom_range(0, 9)), 2'($urandom),
                             8'($urandom), 10'($urandom));
            else if (pick < 96)
                send_command(CMD_CLEAR, 16'($urandom), 16'($urandom), 2'($urandom),
                             8'($urandom), 10'($urandom));
            else
                send_command(3'($urandom_range(6, 7)), 16'($urandom), 16'($urandom),
                             2'($urandom), 8'($urandom), 10'($urandom));
        end
    endtask

    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        shadow_cx     = 8'h00;
        shadow_cy     = 8'h00;
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_plots();
        test_text_cells();
        test_random_traffic(1320);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
